/* rtl/core/msqrt_pkg.sv */
// ----------------------------------------------------------------------------
// msqrt_pkg
// types and constants shared by the modular square root unit
// ----------------------------------------------------------------------------
package msqrt_pkg;

  localparam int unsigned ZLimit = 1024;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] modulus;
  } in_t;

  typedef struct packed {
    logic [31:0] root;
    logic        no_root;
  } out_t;

endpackage

/* rtl/core/modular_square_root_unit.sv */
// ----------------------------------------------------------------------------
// modular_square_root_unit
// tonelli-shanks modular square root over a prime modulus
// ----------------------------------------------------------------------------
// in_ channel takes {value, modulus}; out_ channel returns {root, no_root}.
// one transaction is worked on at a time; in_ready is low while busy.
// every product goes through one shared modular multiplier, which forms
// each product in a register stage and then a shift-subtract remainder.
// moduli below 3 are settled without a multiply, a zero value ends after
// the reduction multiply, and other values go through the euler check by
// square-and-multiply exponentiation; moduli of 3 mod 4 then take the root
// by exponentiation, and moduli of 1 mod 4 run the non-residue search over
// z and the reduction loop. the initial reduction value mod modulus runs on the same
// multiplier. a finished result moves into an output register and the unit
// returns to idle, so the next transaction is accepted while that result
// waits; a later result is held in the sequencer until out_ready frees the
// output register.
// reset clears the sequencer and drops out_valid; no pass is needed.
// ----------------------------------------------------------------------------
module modular_square_root_unit #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msqrt_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msqrt_pkg::out_t   out_data
);

  localparam int unsigned W = MOD_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RED   = 9'b000000010,
    S_EXP   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DISP  = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_BSQ   = 9'b001000000,
    S_UPD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  // what the current exponentiation feeds
  typedef enum logic [5:0] {
    E_EULER = 6'b000001,
    E_R34   = 6'b000010,
    E_ZTST  = 6'b000100,
    E_C     = 6'b001000,
    E_T     = 6'b010000,
    E_R     = 6'b100000
  } ephase_t;

  // steps of an exponent bit and of the update
  typedef enum logic [3:0] {
    M_ACC  = 4'b0001,
    M_BASE = 4'b0010,
    M_RB   = 4'b0100,
    M_CT   = 4'b1000
  } mstep_t;

  state_t  st_r, st_nxt;
  ephase_t ph_r, ph_nxt;
  mstep_t  ms_r, ms_nxt;

  logic [W-1:0] p_r, p_nxt, n_r, n_nxt, q_r, q_nxt, z_r, z_nxt;
  logic [W-1:0] acc_r, acc_nxt, base_r, base_nxt, ex_r, ex_nxt;
  logic [W-1:0] c_r, c_nxt, t_r, t_nxt, rr_r, rr_nxt, b_r, b_nxt, sq_r, sq_nxt;
  logic [5:0]   mm_r, mm_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [W-1:0] root_r, root_nxt;
  logic         fail_r, fail_nxt, ov_r, ov_nxt;
  logic [W-1:0] res_root_r, res_root_nxt;
  logic         res_fail_r, res_fail_nxt;

  logic         mstart;
  logic [W-1:0] ma, mb;
  logic         mdone;
  logic [W-1:0] mres;

  logic [W-1:0] vin, pin, half;
  logic         p_lt2;

  msqrt_mulmod #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .m(p_nxt),
    .done(mdone), .res(mres)
  );

  assign vin      = in_data.value[W-1:0];
  assign pin      = in_data.modulus[W-1:0];
  assign half     = (p_r - W'(1)) >> 1;
  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data.root    = 32'(res_root_r);
  assign out_data.no_root = res_fail_r;
  assign p_lt2    = (pin < W'(2));

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; ms_nxt = ms_r;
    p_nxt = p_r; n_nxt = n_r; q_nxt = q_r; z_nxt = z_r;
    acc_nxt = acc_r; base_nxt = base_r; ex_nxt = ex_r;
    c_nxt = c_r; t_nxt = t_r; rr_nxt = rr_r; b_nxt = b_r; sq_nxt = sq_r;
    mm_nxt = mm_r; i_nxt = i_r; j_nxt = j_r;
    root_nxt = root_r; fail_nxt = fail_r; ov_nxt = ov_r;
    res_root_nxt = res_root_r; res_fail_nxt = res_fail_r;
    mstart = 1'b0; ma = '0; mb = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt = pin; fail_nxt = 1'b0; root_nxt = '0;
          if (p_lt2) begin
            fail_nxt = 1'b1; st_nxt = S_OUT;
          end else if (pin == W'(2)) begin
            root_nxt = W'(vin[0]); st_nxt = S_OUT;
          end else begin
            // v mod p as v*1 mod p
            mstart = 1'b1; ma = vin; mb = W'(1);
            st_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (mdone) begin
          n_nxt = mres;
          if (mres == '0) begin
            root_nxt = '0; st_nxt = S_OUT;
          end else begin
            acc_nxt = W'(1); base_nxt = mres; ex_nxt = half;
            ph_nxt = E_EULER; ms_nxt = M_ACC; st_nxt = S_EXP;
          end
        end
      end
      S_EXP: begin
        if (ex_r == '0) begin
          st_nxt = S_DISP;
        end else if (ms_r == M_ACC) begin
          if (ex_r[0]) begin
            mstart = 1'b1; ma = acc_r; mb = base_r; st_nxt = S_MUL;
          end else begin
            ms_nxt = M_BASE;
          end
        end else begin
          mstart = 1'b1; ma = base_r; mb = base_r; st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mdone) begin
          st_nxt = S_EXP;
          if (ms_r == M_ACC) begin
            acc_nxt = mres; ms_nxt = M_BASE;
          end else begin
            base_nxt = mres; ex_nxt = ex_r >> 1; ms_nxt = M_ACC;
          end
        end
      end
      S_DISP: begin
        ms_nxt = M_ACC;
        case (ph_r)
          E_EULER: begin
            if (acc_r != W'(1)) begin
              fail_nxt = 1'b1; st_nxt = S_OUT;
            end else if (p_r[1:0] == 2'b11) begin
              acc_nxt = W'(1); base_nxt = n_r; ex_nxt = (p_r >> 2) + W'(1);
              ph_nxt = E_R34; st_nxt = S_EXP;
            end else begin
              // q, s by trailing zero strip
              q_nxt = p_r - W'(1); mm_nxt = '0;
              for (int k = 0; k < W; k++) begin
                if (q_nxt[0] == 1'b0) begin
                  q_nxt = q_nxt >> 1; mm_nxt = mm_nxt + 6'd1;
                end
              end
              z_nxt = W'(2);
              if (p_r <= W'(2)) begin
                fail_nxt = 1'b1; st_nxt = S_OUT;
              end else begin
                acc_nxt = W'(1); base_nxt = W'(2); ex_nxt = half;
                ph_nxt = E_ZTST; st_nxt = S_EXP;
              end
            end
          end
          E_R34: begin
            root_nxt = acc_r; st_nxt = S_OUT;
          end
          E_ZTST: begin
            if (acc_r == p_r - W'(1)) begin
              acc_nxt = W'(1); base_nxt = z_r; ex_nxt = q_r;
              ph_nxt = E_C; st_nxt = S_EXP;
            end else if ((z_r + W'(1) >= p_r) ||
                         (33'(z_r) + 33'd1 >= 33'(msqrt_pkg::ZLimit))) begin
              fail_nxt = 1'b1; st_nxt = S_OUT;
            end else begin
              z_nxt = z_r + W'(1);
              acc_nxt = W'(1); base_nxt = z_r + W'(1); ex_nxt = half;
              st_nxt = S_EXP;
            end
          end
          E_C: begin
            c_nxt = acc_r;
            acc_nxt = W'(1); base_nxt = n_r; ex_nxt = q_r;
            ph_nxt = E_T; st_nxt = S_EXP;
          end
          E_T: begin
            t_nxt = acc_r;
            acc_nxt = W'(1); base_nxt = n_r; ex_nxt = (q_r >> 1) + W'(1);
            ph_nxt = E_R; st_nxt = S_EXP;
          end
          default: begin
            rr_nxt = acc_r;
            sq_nxt = t_r; i_nxt = '0; st_nxt = S_SQ;
          end
        endcase
      end
      S_SQ: begin
        if (t_r == W'(1)) begin
          root_nxt = rr_r; st_nxt = S_OUT;
        end else if (t_r == '0) begin
          root_nxt = '0; st_nxt = S_OUT;
        end else if (sq_r != W'(1) && i_r < mm_r) begin
          if (!ms_r[1]) begin
            mstart = 1'b1; ma = sq_r; mb = sq_r; ms_nxt = M_BASE;
          end else if (mdone) begin
            sq_nxt = mres; i_nxt = i_r + 6'd1; ms_nxt = M_ACC;
          end
        end else if (i_r >= mm_r) begin
          fail_nxt = 1'b1; st_nxt = S_OUT;
        end else begin
          b_nxt = c_r; j_nxt = '0; ms_nxt = M_ACC; st_nxt = S_BSQ;
        end
      end
      S_BSQ: begin
        if (j_r + 6'd1 < mm_r - i_r) begin
          if (!ms_r[1]) begin
            mstart = 1'b1; ma = b_r; mb = b_r; ms_nxt = M_BASE;
          end else if (mdone) begin
            b_nxt = mres; j_nxt = j_r + 6'd1; ms_nxt = M_ACC;
          end
        end else begin
          mstart = 1'b1; ma = rr_r; mb = b_r; ms_nxt = M_RB; st_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (mdone) begin
          case (ms_r)
            M_RB: begin
              rr_nxt = mres; mstart = 1'b1; ma = b_r; mb = b_r; ms_nxt = M_CT;
            end
            M_CT: begin
              c_nxt = mres; mstart = 1'b1; ma = t_r; mb = mres; ms_nxt = M_ACC;
            end
            default: begin
              t_nxt = mres; mm_nxt = i_r;
              sq_nxt = mres; i_nxt = '0; st_nxt = S_SQ;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          res_root_nxt = fail_r ? '0 : root_r;
          res_fail_nxt = fail_r;
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt; n_r <= n_nxt; q_r <= q_nxt; z_r <= z_nxt;
    acc_r <= acc_nxt; base_r <= base_nxt; ex_r <= ex_nxt;
    c_r <= c_nxt; t_r <= t_nxt; rr_r <= rr_nxt; b_r <= b_nxt; sq_r <= sq_nxt;
    mm_r <= mm_nxt; i_r <= i_nxt; j_r <= j_nxt;
    root_r <= root_nxt; fail_r <= fail_nxt; ph_r <= ph_nxt; ms_r <= ms_nxt;
    res_root_r <= res_root_nxt; res_fail_r <= res_fail_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

/* rtl/core/msqrt_mulmod.sv */
// ----------------------------------------------------------------------------
// msqrt_mulmod
// multi-cycle modular multiplier: registered product, then bit-serial remainder
// ----------------------------------------------------------------------------
module msqrt_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int unsigned CW = $clog2(2*W+1);

  logic [2*W-1:0] prod_r, prod_nxt;
  logic [W:0]     rem_r, rem_nxt;
  logic [W-1:0]   m_r, m_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     sh;

  assign done = done_r;
  assign res  = rem_r[W-1:0];

  always_comb begin
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[W-1:0], prod_r[2*W-1]};
    if (start) begin
      prod_nxt = a * b;
      m_nxt    = m;
      rem_nxt  = '0;
      cnt_nxt  = CW'(2*W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {prod_r[2*W-2:0], 1'b0};
      if (sh >= {1'b0, m_r}) begin
        rem_nxt = sh - {1'b0, m_r};
      end else begin
        rem_nxt = sh;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    m_r    <= m_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
